FILE: src/tmid_pkg.sv
`default_nettype none

package tmid_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COMP_W        = 33;
  localparam int unsigned LEN_W         = 31;
  localparam int unsigned BOX_W         = 32;
  localparam int unsigned SQ_W          = 64;
  localparam int unsigned QUO_W         = 33;
  localparam int unsigned SFT_W         = 35;
  localparam int unsigned SMAG_W        = 34;
  localparam int unsigned PROD_W        = SMAG_W + BOX_W;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_AX        = 3;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t COMP_HI = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_LO = {1'b1, {(COMP_W-1){1'b0}}};

  localparam logic [PROD_W-1:0] PROD_LIM = PROD_W'(64'd1 << 34);

  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_Z = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_XX = 3'd0,
    CFG_BOX_YY = 3'd1,
    CFG_BOX_ZZ = 3'd2,
    CFG_BOX_YX = 3'd3,
    CFG_BOX_ZX = 3'd4,
    CFG_BOX_ZY = 3'd5
  } cfg_idx_e;

  function automatic logic [COMP_W-1:0] comp_mag(input comp_t c);
    logic [COMP_W-1:0] r;
    r = c[COMP_W-1] ? COMP_W'(-c) : COMP_W'(c);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] comp_sat32(input comp_t c);
    logic [DATA_W-1:0] r;
    if (c[COMP_W-1:COMP_W-2] == 2'b01) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (c[COMP_W-1:COMP_W-2] == 2'b10) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = c[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/triclinic_minimum_image_distance.sv
// Channel  Direction  Handshake                   Payload
// input    in         in_valid_i / in_ready_o     first_{x,y,z}_i, second_{x,y,z}_i
// output   out        out_valid_o / out_ready_i   wrapped_d{x,y,z}_o, squared_length_o
// config   in         cfg_we_i (no stall)         cfg_idx_i, cfg_data_i
// One beat is accepted per cycle while the queue has room; each beat passes through
// the queue, three bit-serial pipelined dividers (33 stages and three scale
// steps each) and three squaring stages.
// Reset restores the box to a unit cube; there is no clearing pass.
// An unclaimed result halts the back pipeline, and a four-beat queue keeps
// accepting input beats until it fills.
`default_nettype none

module triclinic_minimum_image_distance #(
  parameter int unsigned FRAC_BITS = tmid_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire        [tmid_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire        [tmid_pkg::BOX_W-1:0]     cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   first_x_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   first_y_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   first_z_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   second_x_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   second_y_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0]   second_z_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [tmid_pkg::DATA_W-1:0]   wrapped_dx_o,
  output logic signed [tmid_pkg::DATA_W-1:0]   wrapped_dy_o,
  output logic signed [tmid_pkg::DATA_W-1:0]   wrapped_dz_o,
  output logic       [tmid_pkg::SQ_W-1:0]      squared_length_o
);

  localparam logic [tmid_pkg::LEN_W-1:0] LEN_ONE = tmid_pkg::LEN_W'(64'd1 << FRAC_BITS);

  logic [tmid_pkg::LEN_W-1:0]        box_xx_q, box_yy_q, box_zz_q;
  logic signed [tmid_pkg::BOX_W-1:0] box_yx_q, box_zx_q, box_zy_q;

  logic            head_valid, back_ready, pop;
  tmid_pkg::comp_t head_c [tmid_pkg::NUM_AX];
  logic [tmid_pkg::DATA_W-1:0] dx, dy, dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_xx_q <= LEN_ONE;
      box_yy_q <= LEN_ONE;
      box_zz_q <= LEN_ONE;
      box_yx_q <= '0;
      box_zx_q <= '0;
      box_zy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmid_pkg::CFG_BOX_XX: box_xx_q <= cfg_data_i[tmid_pkg::LEN_W-1:0];
        tmid_pkg::CFG_BOX_YY: box_yy_q <= cfg_data_i[tmid_pkg::LEN_W-1:0];
        tmid_pkg::CFG_BOX_ZZ: box_zz_q <= cfg_data_i[tmid_pkg::LEN_W-1:0];
        tmid_pkg::CFG_BOX_YX: box_yx_q <= $signed(cfg_data_i);
        tmid_pkg::CFG_BOX_ZX: box_zx_q <= $signed(cfg_data_i);
        tmid_pkg::CFG_BOX_ZY: box_zy_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign pop = head_valid && back_ready;

  tmid_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .first_x_i, .first_y_i, .first_z_i,
    .second_x_i, .second_y_i, .second_z_i,
    .head_valid_o(head_valid), .pop_i(pop), .head_c_o(head_c)
  );

  tmid_back u_back (
    .clk_i, .rst_ni,
    .valid_i(head_valid), .ready_o(back_ready), .c_i(head_c),
    .box_xx_i(box_xx_q), .box_yy_i(box_yy_q), .box_zz_i(box_zz_q),
    .box_yx_i(box_yx_q), .box_zx_i(box_zx_q), .box_zy_i(box_zy_q),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .dx_o(dx), .dy_o(dy), .dz_o(dz), .sq_o(squared_length_o)
  );

  assign wrapped_dx_o = $signed(dx);
  assign wrapped_dy_o = $signed(dy);
  assign wrapped_dz_o = $signed(dz);

endmodule

`default_nettype wire

FILE: src/tmid_front.sv
`default_nettype none

module tmid_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  output logic                              ready_o,
  input  wire  signed [tmid_pkg::DATA_W-1:0] first_x_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0] first_y_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0] first_z_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0] second_x_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0] second_y_i,
  input  wire  signed [tmid_pkg::DATA_W-1:0] second_z_i,
  output logic                              head_valid_o,
  input  wire                               pop_i,
  output tmid_pkg::comp_t                   head_c_o [tmid_pkg::NUM_AX]
);

  localparam int unsigned PTR_W = $clog2(tmid_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  tmid_pkg::comp_t mem_x [tmid_pkg::FIFO_DEPTH];
  tmid_pkg::comp_t mem_y [tmid_pkg::FIFO_DEPTH];
  tmid_pkg::comp_t mem_z [tmid_pkg::FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  tmid_pkg::comp_t  diff [tmid_pkg::NUM_AX];

  assign diff[tmid_pkg::AX_X] = tmid_pkg::comp_t'($signed({first_x_i[tmid_pkg::DATA_W-1], first_x_i})
                              - $signed({second_x_i[tmid_pkg::DATA_W-1], second_x_i}));
  assign diff[tmid_pkg::AX_Y] = tmid_pkg::comp_t'($signed({first_y_i[tmid_pkg::DATA_W-1], first_y_i})
                              - $signed({second_y_i[tmid_pkg::DATA_W-1], second_y_i}));
  assign diff[tmid_pkg::AX_Z] = tmid_pkg::comp_t'($signed({first_z_i[tmid_pkg::DATA_W-1], first_z_i})
                              - $signed({second_z_i[tmid_pkg::DATA_W-1], second_z_i}));

  assign ready_o      = (count_q != CNT_W'(tmid_pkg::FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign push         = valid_i && ready_o;

  assign head_c_o[tmid_pkg::AX_X] = mem_x[rd_ptr_q];
  assign head_c_o[tmid_pkg::AX_Y] = mem_y[rd_ptr_q];
  assign head_c_o[tmid_pkg::AX_Z] = mem_z[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_x[wr_ptr_q] <= diff[tmid_pkg::AX_X];
      mem_y[wr_ptr_q] <= diff[tmid_pkg::AX_Y];
      mem_z[wr_ptr_q] <= diff[tmid_pkg::AX_Z];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/tmid_wrap.sv
`default_nettype none

module tmid_wrap #(
  parameter int unsigned PIVOT = 0
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               en_i,
  input  wire                               valid_i,
  input  tmid_pkg::comp_t                   c_i [tmid_pkg::NUM_AX],
  input  wire        [tmid_pkg::LEN_W-1:0]  len_i,
  input  wire  signed [tmid_pkg::BOX_W-1:0] b_i [tmid_pkg::NUM_AX],
  output logic                              valid_o,
  output tmid_pkg::comp_t                   c_o [tmid_pkg::NUM_AX]
);

  localparam int unsigned NST = tmid_pkg::QUO_W;
  localparam int unsigned LW  = tmid_pkg::LEN_W;
  localparam int unsigned CW  = tmid_pkg::COMP_W;
  localparam int unsigned NA  = tmid_pkg::NUM_AX;

  logic                dv_q   [NST];
  logic [LW-1:0]       rem_q  [NST], rem_d [NST];
  logic [CW-1:0]       a_q    [NST], a_d   [NST];
  logic [NST-1:0]      qt_q   [NST], qt_d  [NST];
  logic                neg_q  [NST];
  tmid_pkg::comp_t     dc_q   [NST][NA];

  logic                        rv_q;
  logic signed [tmid_pkg::SFT_W-1:0] s_q, s_d;
  tmid_pkg::comp_t             rc_q [NA];

  logic                        mv_q;
  logic [tmid_pkg::PROD_W-1:0] m_q [NA], m_d [NA];
  logic                        mneg_q [NA], mneg_d [NA];
  tmid_pkg::comp_t             mc_q [NA];

  tmid_pkg::comp_t             c_d [NA];

  always_comb begin
    logic [LW-1:0]  rp;
    logic [CW-1:0]  ap;
    logic [NST-1:0] qp;
    logic [LW:0]    t;
    logic           ge;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        rp = '0;
        ap = tmid_pkg::comp_mag(c_i[PIVOT]);
        qp = '0;
      end else begin
        rp = rem_q[k-1];
        ap = a_q[k-1];
        qp = qt_q[k-1];
      end
      t        = {rp, ap[CW-1]};
      ge       = (t >= {1'b0, len_i});
      rem_d[k] = ge ? LW'(t - {1'b0, len_i}) : LW'(t);
      a_d[k]   = {ap[CW-2:0], 1'b0};
      qt_d[k]  = {qp[NST-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NST; k++) begin
        rem_q[k] <= rem_d[k];
        a_q[k]   <= a_d[k];
        qt_q[k]  <= qt_d[k];
        if (k == 0) begin
          neg_q[k] <= c_i[PIVOT][CW-1];
          for (int j = 0; j < NA; j++) begin
            dc_q[k][j] <= c_i[j];
          end
        end else begin
          neg_q[k] <= neg_q[k-1];
          for (int j = 0; j < NA; j++) begin
            dc_q[k][j] <= dc_q[k-1][j];
          end
        end
      end
    end
  end

  always_comb begin
    logic [LW:0]    twor;
    logic [LW:0]    lenx;
    logic           up;
    logic [NST:0]   qr;
    twor = {rem_q[NST-1], 1'b0};
    lenx = {1'b0, len_i};
    up   = (twor > lenx) || ((twor == lenx) && qt_q[NST-1][0]);
    qr   = {1'b0, qt_q[NST-1]} + (NST+1)'(up);
    if (len_i == '0) begin
      s_d = '0;
    end else if (neg_q[NST-1]) begin
      s_d = -$signed({1'b0, qr});
    end else begin
      s_d = $signed({1'b0, qr});
    end
  end

  always_comb begin
    logic [tmid_pkg::SMAG_W-1:0] ms;
    logic [tmid_pkg::BOX_W-1:0]  mb;
    ms = s_q[tmid_pkg::SFT_W-1] ? tmid_pkg::SMAG_W'(-s_q) : tmid_pkg::SMAG_W'(s_q);
    for (int j = 0; j < NA; j++) begin
      mb        = b_i[j][tmid_pkg::BOX_W-1] ? tmid_pkg::BOX_W'(-b_i[j])
                                            : tmid_pkg::BOX_W'(b_i[j]);
      m_d[j]    = tmid_pkg::PROD_W'(ms) * tmid_pkg::PROD_W'(mb);
      mneg_d[j] = s_q[tmid_pkg::SFT_W-1] != b_i[j][tmid_pkg::BOX_W-1];
    end
  end

  always_comb begin
    logic signed [CW+3:0] t;
    logic signed [CW+3:0] mx;
    for (int j = 0; j < NA; j++) begin
      mx = $signed({2'b0, m_q[j][CW+1:0]});
      t  = mneg_q[j] ? $signed({{4{mc_q[j][CW-1]}}, mc_q[j]}) + mx
                     : $signed({{4{mc_q[j][CW-1]}}, mc_q[j]}) - mx;
      if (m_q[j] == '0) begin
        c_d[j] = mc_q[j];
      end else if (m_q[j] > tmid_pkg::PROD_LIM) begin
        c_d[j] = mneg_q[j] ? tmid_pkg::COMP_HI : tmid_pkg::COMP_LO;
      end else if (t > $signed({{4{1'b0}}, tmid_pkg::COMP_HI})) begin
        c_d[j] = tmid_pkg::COMP_HI;
      end else if (t < $signed({{4{1'b1}}, tmid_pkg::COMP_LO})) begin
        c_d[j] = tmid_pkg::COMP_LO;
      end else begin
        c_d[j] = tmid_pkg::comp_t'(t);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
      for (int j = 0; j < NA; j++) begin
        rc_q[j]   <= dc_q[NST-1][j];
        m_q[j]    <= m_d[j];
        mneg_q[j] <= mneg_d[j];
        mc_q[j]   <= rc_q[j];
        c_o[j]    <= c_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        dv_q[k] <= 1'b0;
      end
      rv_q    <= 1'b0;
      mv_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < NST; k++) begin
        if (k == 0) begin
          dv_q[k] <= valid_i;
        end else begin
          dv_q[k] <= dv_q[k-1];
        end
      end
      rv_q    <= dv_q[NST-1];
      mv_q    <= rv_q;
      valid_o <= mv_q;
    end
  end

endmodule

`default_nettype wire

FILE: src/tmid_back.sv
`default_nettype none

module tmid_back (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  output logic                              ready_o,
  input  tmid_pkg::comp_t                   c_i [tmid_pkg::NUM_AX],
  input  wire        [tmid_pkg::LEN_W-1:0]  box_xx_i,
  input  wire        [tmid_pkg::LEN_W-1:0]  box_yy_i,
  input  wire        [tmid_pkg::LEN_W-1:0]  box_zz_i,
  input  wire  signed [tmid_pkg::BOX_W-1:0] box_yx_i,
  input  wire  signed [tmid_pkg::BOX_W-1:0] box_zx_i,
  input  wire  signed [tmid_pkg::BOX_W-1:0] box_zy_i,
  output logic                              valid_o,
  input  wire                               ready_i,
  output logic       [tmid_pkg::DATA_W-1:0] dx_o,
  output logic       [tmid_pkg::DATA_W-1:0] dy_o,
  output logic       [tmid_pkg::DATA_W-1:0] dz_o,
  output logic       [tmid_pkg::SQ_W-1:0]   sq_o
);

  localparam int unsigned NA = tmid_pkg::NUM_AX;
  localparam int unsigned SW = tmid_pkg::SQ_W;

  logic                en;
  logic                zv, yv, xv;
  tmid_pkg::comp_t     zc [NA], yc [NA], xc [NA];
  logic signed [tmid_pkg::BOX_W-1:0] bz [NA], by [NA], bx [NA];

  logic                pv_q;
  logic [SW-1:0]       p_q [NA];
  logic                psat_q [NA];
  tmid_pkg::comp_t     pc_q [NA];

  logic                av_q;
  logic [SW-1:0]       a_q;
  logic                asat_q;
  logic [SW-1:0]       az_q;
  logic                azsat_q;
  tmid_pkg::comp_t     ac_q [NA];

  logic [SW:0]         sum1, sum2;

  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  assign bz[tmid_pkg::AX_X] = box_zx_i;
  assign bz[tmid_pkg::AX_Y] = box_zy_i;
  assign bz[tmid_pkg::AX_Z] = $signed({1'b0, box_zz_i});
  assign by[tmid_pkg::AX_X] = box_yx_i;
  assign by[tmid_pkg::AX_Y] = $signed({1'b0, box_yy_i});
  assign by[tmid_pkg::AX_Z] = '0;
  assign bx[tmid_pkg::AX_X] = $signed({1'b0, box_xx_i});
  assign bx[tmid_pkg::AX_Y] = '0;
  assign bx[tmid_pkg::AX_Z] = '0;

  tmid_wrap #(.PIVOT(tmid_pkg::AX_Z)) u_wrap_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i, .c_i, .len_i(box_zz_i), .b_i(bz),
    .valid_o(zv), .c_o(zc)
  );

  tmid_wrap #(.PIVOT(tmid_pkg::AX_Y)) u_wrap_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(zv), .c_i(zc), .len_i(box_yy_i), .b_i(by),
    .valid_o(yv), .c_o(yc)
  );

  tmid_wrap #(.PIVOT(tmid_pkg::AX_X)) u_wrap_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(yv), .c_i(yc), .len_i(box_xx_i), .b_i(bx),
    .valid_o(xv), .c_o(xc)
  );

  assign sum1 = {1'b0, p_q[tmid_pkg::AX_X]} + {1'b0, p_q[tmid_pkg::AX_Y]};
  assign sum2 = {1'b0, a_q} + {1'b0, az_q};

  always_ff @(posedge clk_i) begin
    logic [tmid_pkg::COMP_W-1:0] am;
    if (en) begin
      for (int j = 0; j < NA; j++) begin
        am        = tmid_pkg::comp_mag(xc[j]);
        p_q[j]    <= SW'(am[tmid_pkg::DATA_W-1:0]) * SW'(am[tmid_pkg::DATA_W-1:0]);
        psat_q[j] <= am[tmid_pkg::COMP_W-1];
        pc_q[j]   <= xc[j];
        ac_q[j]   <= pc_q[j];
      end
      a_q     <= sum1[SW-1:0];
      asat_q  <= psat_q[tmid_pkg::AX_X] || psat_q[tmid_pkg::AX_Y] || sum1[SW];
      az_q    <= p_q[tmid_pkg::AX_Z];
      azsat_q <= psat_q[tmid_pkg::AX_Z];
      dx_o    <= tmid_pkg::comp_sat32(ac_q[tmid_pkg::AX_X]);
      dy_o    <= tmid_pkg::comp_sat32(ac_q[tmid_pkg::AX_Y]);
      dz_o    <= tmid_pkg::comp_sat32(ac_q[tmid_pkg::AX_Z]);
      sq_o    <= (asat_q || azsat_q || sum2[SW]) ? {SW{1'b1}} : sum2[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      av_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      pv_q    <= xv;
      av_q    <= pv_q;
      valid_o <= av_q;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_triclinic_minimum_image_distance.sv
`timescale 1ns / 1ps

module tb_triclinic_minimum_image_distance;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] dx, dy, dz;
    logic [63:0]        sq;
  } disp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tmid_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [tmid_pkg::BOX_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [31:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] wrapped_dx_o, wrapped_dy_o, wrapped_dz_o;
  logic [63:0] squared_length_o;

  triclinic_minimum_image_distance DUT (.*);

  always #5 clk_i = ~clk_i;

  longint unsigned len_xx, len_yy, len_zz;
  longint tilt_yx, tilt_zx, tilt_zy;

  pair_t pending_pairs[$];
  disp_t expected_disps[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned hold_cycles = 0;
  bit quiet_mode = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;

  function automatic longint clamp33(longint v);
    if (v > 64'sd4294967295) return 64'sd4294967295;
    if (v < -64'sd4294967296) return -64'sd4294967296;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint nearest_shift(longint c, longint unsigned l);
    longint unsigned a, q, r;
    if (l == 0) return 0;
    a = absval(c);
    q = a / l;
    r = a % l;
    if (2 * r > l || (2 * r == l && q[0])) q++;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shift_back(longint c, longint s, longint b);
    longint unsigned m;
    bit neg;
    m = absval(s) * absval(b);
    neg = (s < 0) != (b < 0);
    if (m == 0) return c;
    if (m > 64'd17179869184) return neg ? 64'sd4294967295 : -64'sd4294967296;
    return neg ? clamp33(c + longint'(m)) : clamp33(c - longint'(m));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] square_clamped(longint v);
    longint unsigned a;
    a = absval(v);
    if (a >= 64'd4294967296) return '1;
    return a * a;
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic disp_t min_image(pair_t p);
    longint dx, dy, dz, s;
    disp_t r;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    dz = longint'(p.az) - longint'(p.bz);
    s = nearest_shift(dz, len_zz);
    dz = shift_back(dz, s, longint'(len_zz));
    dy = shift_back(dy, s, tilt_zy);
    dx = shift_back(dx, s, tilt_zx);
    s = nearest_shift(dy, len_yy);
    dy = shift_back(dy, s, longint'(len_yy));
    dx = shift_back(dx, s, tilt_yx);
    s = nearest_shift(dx, len_xx);
    dx = shift_back(dx, s, longint'(len_xx));
    r.dx = clamp32(dx);
    r.dy = clamp32(dy);
    r.dz = clamp32(dz);
    r.sq = add_clamped(add_clamped(square_clamped(dx), square_clamped(dy)),
                       square_clamped(dz));
    return r;
  endfunction

  task automatic write_box(tmid_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tmid_pkg::CFG_BOX_XX: len_xx = val[30:0];
      tmid_pkg::CFG_BOX_YY: len_yy = val[30:0];
      tmid_pkg::CFG_BOX_ZZ: len_zz = val[30:0];
      tmid_pkg::CFG_BOX_YX: tilt_yx = longint'(signed'(val));
      tmid_pkg::CFG_BOX_ZX: tilt_zx = longint'(signed'(val));
      default: tilt_zy = longint'(signed'(val));
    endcase
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
      default: return mode == 0 ? $urandom()
                                : 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic pair_t random_pair(int mode);
    pair_t p;
    p.ax = pick_coord(mode);
    p.ay = pick_coord(mode);
    p.az = pick_coord(mode);
    p.bx = pick_coord(mode);
    p.by = pick_coord(mode);
    p.bz = pick_coord(mode);
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid_i || expected_disps.size() != 0)
      @(negedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_disps = {expected_disps, min_image({first_x_i, first_y_i, first_z_i,
                                                     second_x_i, second_y_i, second_z_i})};
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pairs.size() != 0 && (quiet_mode || $urandom_range(0, 99) >= 11)) begin
          {first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i}
            <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    disp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_disps.size() == 0) begin
          $display("%0t: unexpected result dx=%h", $time, wrapped_dx_o);
          error_count++;
        end else begin
          want = expected_disps.pop_front();
          if (wrapped_dx_o !== want.dx) begin
            $display("%0t: dx expected %h actual %h", $time, want.dx, wrapped_dx_o);
            error_count++;
          end
          if (wrapped_dy_o !== want.dy) begin
            $display("%0t: dy expected %h actual %h", $time, want.dy, wrapped_dy_o);
            error_count++;
          end
          if (wrapped_dz_o !== want.dz) begin
            $display("%0t: dz expected %h actual %h", $time, want.dz, wrapped_dz_o);
            error_count++;
          end
          if (squared_length_o !== want.sq) begin
            $display("%0t: squared length expected %h actual %h", $time, want.sq,
                     squared_length_o);
            error_count++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done <= 1'b1;
        hold_cycles <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= hold_cycles == 1;
      end else begin
        out_ready_i <= quiet_mode || $urandom_range(0, 99) >= 11;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    pair_t p;
    len_xx = 65536;
    len_yy = 65536;
    len_zz = 65536;
    tilt_yx = 0;
    tilt_zx = 0;
    tilt_zy = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_pairs = {pending_pairs, pair_t'({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                             32'h80000000, 32'h80000000, 32'h80000000})};
    pending_pairs = {pending_pairs, pair_t'({32'h80000000, 32'h80000000, 32'h80000000,
                                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff})};
    pending_pairs = {pending_pairs, pair_t'('0)};
    pending_pairs = {pending_pairs, pair_t'({32'h00008000, 32'h00018000, 32'h00028000,
                                             32'h0, 32'h0, 32'h0})};
    pending_pairs = {pending_pairs, pair_t'({32'hffff8000, 32'hfffe8000, 32'hfffd8000,
                                             32'h0, 32'h0, 32'h0})};
    pending_pairs = {pending_pairs, pair_t'({32'h00010000, 32'h0, 32'hffffffff,
                                             32'h0, 32'h1, 32'h0})};
    wait_drained();

    write_box(tmid_pkg::CFG_BOX_XX, 32'h0);
    write_box(tmid_pkg::CFG_BOX_YY, 32'h7fffffff);
    write_box(tmid_pkg::CFG_BOX_ZZ, 32'h1);
    write_box(tmid_pkg::CFG_BOX_YX, 32'h7fffffff);
    write_box(tmid_pkg::CFG_BOX_ZX, 32'h80000000);
    write_box(tmid_pkg::CFG_BOX_ZY, 32'h80000000);
    repeat (8) pending_pairs = {pending_pairs, random_pair(0)};
    pending_pairs = {pending_pairs, pair_t'({32'h7fffffff, 32'h0, 32'h7fffffff,
                                             32'h80000000, 32'h0, 32'h80000000})};
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_box(tmid_pkg::CFG_BOX_XX, $urandom_range(1, 5) << $urandom_range(10, 18));
      write_box(tmid_pkg::CFG_BOX_YY, $urandom_range(1, 5) << $urandom_range(10, 18));
      write_box(tmid_pkg::CFG_BOX_ZZ,
                ph == 5 ? 32'h7fffffff : $urandom_range(1, 5) << 16);
      write_box(tmid_pkg::CFG_BOX_YX,
                ph == 0 ? 32'h0 : 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16)));
      write_box(tmid_pkg::CFG_BOX_ZX,
                ph == 0 ? 32'h0 : (ph == 4 ? $urandom()
                                  : 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16))));
      write_box(tmid_pkg::CFG_BOX_ZY,
                ph == 0 ? 32'h0 : 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16)));
      quiet_mode = ph == 2;
      if (ph == 1) hold_armed = 1'b1;
      for (int i = 0; i < 300; i++) begin
        p = random_pair(($urandom_range(0, 3) == 0) ? 0 : 1);
        pending_pairs = {pending_pairs, p};
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
